### rtl/tilt_pkg.sv
package tilt_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int AXIS_W     = SAMPLE_W + 1;
  localparam int ANGLE_W    = 16;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int ACC_FRAC   = 16;
  localparam int XY_W       = 28;
  localparam int Z_W        = 25;
  localparam int TAB_IDX_W  = 5;
  localparam int TAB_LEN    = 24;

  typedef logic [SAMPLE_W-1:0]          sample_t;
  typedef logic signed [AXIS_W-1:0]     axis_t;
  typedef logic signed [ANGLE_W-1:0]    angle_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic signed [XY_W-1:0]       xy_t;
  typedef logic signed [Z_W-1:0]        zacc_t;
  typedef logic [1:0]                   pair_t;

  localparam cfg_idx_t REG_SAMPLE_OFFSET = 1'd0;
  localparam cfg_idx_t REG_ARM_THRESHOLD = 1'd1;

  localparam sample_t RESET_OFFSET    = 8'd81;
  localparam sample_t RESET_THRESHOLD = 8'd132;

  localparam pair_t PAIR_XY = 2'd0;
  localparam pair_t PAIR_XZ = 2'd1;
  localparam pair_t PAIR_YZ = 2'd2;

  localparam angle_t ANGLE_MAX = 16'sh7fff;
  localparam angle_t ANGLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } tilt_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_ROUND,
    CS_DONE
  } cordic_state_t;

  typedef struct packed {
    logic  start;
    axis_t num;
    axis_t den;
  } cordic_req_t;

  typedef struct packed {
    logic   done;
    angle_t result;
  } cordic_rsp_t;

  function automatic zacc_t atan_step(input logic [TAB_IDX_W-1:0] idx);
    zacc_t t;
    case (idx)
      5'd0:    t = 25'sd2949120;
      5'd1:    t = 25'sd1740967;
      5'd2:    t = 25'sd919879;
      5'd3:    t = 25'sd466945;
      5'd4:    t = 25'sd234379;
      5'd5:    t = 25'sd117304;
      5'd6:    t = 25'sd58666;
      5'd7:    t = 25'sd29335;
      5'd8:    t = 25'sd14668;
      5'd9:    t = 25'sd7334;
      5'd10:   t = 25'sd3667;
      5'd11:   t = 25'sd1833;
      5'd12:   t = 25'sd917;
      5'd13:   t = 25'sd458;
      5'd14:   t = 25'sd229;
      5'd15:   t = 25'sd115;
      5'd16:   t = 25'sd57;
      5'd17:   t = 25'sd29;
      5'd18:   t = 25'sd14;
      5'd19:   t = 25'sd7;
      5'd20:   t = 25'sd4;
      5'd21:   t = 25'sd2;
      5'd22:   t = 25'sd1;
      default: t = 25'sd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/tilt_in_if.sv
interface tilt_in_if;
  logic              valid;
  logic              ready;
  tilt_pkg::sample_t ax_sample;
  tilt_pkg::sample_t ay_sample;
  tilt_pkg::sample_t az_sample;
  tilt_pkg::sample_t arm_sample;

  modport source (output valid, ax_sample, ay_sample, az_sample, arm_sample, input ready);
  modport sink (input valid, ax_sample, ay_sample, az_sample, arm_sample, output ready);
endinterface

### rtl/tilt_out_if.sv
interface tilt_out_if;
  logic             valid;
  logic             ready;
  tilt_pkg::angle_t angle_xy;
  tilt_pkg::angle_t angle_xz;
  tilt_pkg::angle_t angle_yz;
  logic             angles_fresh;

  modport source (output valid, angle_xy, angle_xz, angle_yz, angles_fresh, input ready);
  modport sink (input valid, angle_xy, angle_xz, angle_yz, angles_fresh, output ready);
endinterface

### rtl/accelerometer_tilt_angles.sv
// Tilt angles from three accelerometer axes.
// An item on samples carries raw x, y and z samples and an arm sample. The
// configured zero offset is subtracted from each axis. If the arm sample is
// above the threshold, atan(x/y), atan(z/x) and atan(y/z) are worked out in
// signed degrees with ANGLE_FRAC_BITS fraction bits and latched; otherwise
// the last latched angles are sent again with angles_fresh low.
// The three angles share one vectoring CORDIC that does one iteration per
// cycle; an armed item finishes sooner when a numerator or denominator is
// zero, and an item that is not armed goes straight to the output.
// samples.ready is high only while the sequencer is idle, so no new item
// is accepted until the block is through with the last one and has handed
// its result to the output register.
// The result sits in an output register until the receiver takes it; a new
// item may be accepted meanwhile, and its result waits for the register.
// Reset clears the latched angles to zero, loads offset 81 and threshold 132
// and drops angles.valid. Registers must be written through cfg_write,
// cfg_index and cfg_data while the block is idle, which it does not enforce.
module accelerometer_tilt_angles #(
  parameter int ANGLE_FRAC_BITS   = 8,
  parameter int ARCTAN_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  tilt_pkg::cfg_idx_t  cfg_index,
  input  tilt_pkg::cfg_data_t cfg_data,
  tilt_in_if.sink             samples,
  tilt_out_if.source          angles
);
  import tilt_pkg::*;

  tilt_state_t state, state_next;
  sample_t     sample_offset, arm_threshold;
  axis_t       ax, ay, az;
  logic        armed;
  pair_t       pair;
  angle_t      held_xy, held_xz, held_yz;
  logic        out_valid;
  angle_t      out_xy, out_xz, out_yz;
  logic        out_fresh;
  logic        accept, arm_now, out_free, load_out, capture;
  cordic_req_t req;
  cordic_rsp_t rsp;

  tilt_cordic #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
    .ARCTAN_ITERATIONS(ARCTAN_ITERATIONS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  assign accept   = samples.valid && samples.ready;
  assign arm_now  = samples.arm_sample > arm_threshold;
  assign out_free = !out_valid || angles.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = arm_now ? ST_LAUNCH : ST_OUT;
        end
      end
      ST_LAUNCH: state_next = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          state_next = (pair == PAIR_YZ) ? ST_OUT : ST_LAUNCH;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (state == ST_IDLE);
    req.start     = (state == ST_LAUNCH);
    capture       = (state == ST_WAIT) && rsp.done;
    load_out      = (state == ST_OUT) && out_free;
    case (pair)
      PAIR_XY: begin
        req.num = ax;
        req.den = ay;
      end
      PAIR_XZ: begin
        req.num = az;
        req.den = ax;
      end
      PAIR_YZ: begin
        req.num = ay;
        req.den = az;
      end
      default: begin
        req.num = '0;
        req.den = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_offset <= RESET_OFFSET;
      arm_threshold <= RESET_THRESHOLD;
      pair          <= PAIR_XY;
      armed         <= 1'b0;
      held_xy       <= '0;
      held_xz       <= '0;
      held_yz       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLE_OFFSET: sample_offset <= cfg_data;
          REG_ARM_THRESHOLD: arm_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        armed <= arm_now;
        pair  <= PAIR_XY;
      end
      if (capture) begin
        case (pair)
          PAIR_XY: held_xy <= rsp.result;
          PAIR_XZ: held_xz <= rsp.result;
          PAIR_YZ: held_yz <= rsp.result;
          default: ;
        endcase
        pair <= (pair == PAIR_YZ) ? PAIR_XY : pair + 2'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (angles.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax <= AXIS_W'({1'b0, samples.ax_sample}) - AXIS_W'({1'b0, sample_offset});
      ay <= AXIS_W'({1'b0, samples.ay_sample}) - AXIS_W'({1'b0, sample_offset});
      az <= AXIS_W'({1'b0, samples.az_sample}) - AXIS_W'({1'b0, sample_offset});
    end
    if (load_out) begin
      out_xy    <= held_xy;
      out_xz    <= held_xz;
      out_yz    <= held_yz;
      out_fresh <= armed;
    end
  end

  assign angles.valid        = out_valid;
  assign angles.angle_xy     = out_xy;
  assign angles.angle_xz     = out_xz;
  assign angles.angle_yz     = out_yz;
  assign angles.angles_fresh = out_fresh;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == ST_WAIT)
    else $error("arctangent finished while the sequencer was not waiting");
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && rsp.done && pair == PAIR_YZ) |=> state == ST_OUT)
    else $error("sequencer did not finish after the third angle");
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    pair == PAIR_XY || pair == PAIR_XZ || pair == PAIR_YZ)
    else $error("angle pair index out of range");
  a_held_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !arm_now) |=> (state == ST_OUT && !armed))
    else $error("unarmed item did not go straight to the output");
`endif

endmodule

### rtl/tilt_cordic.sv
module tilt_cordic #(
  parameter int ANGLE_FRAC_BITS   = 8,
  parameter int ARCTAN_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tilt_pkg::cordic_req_t req,
  output tilt_pkg::cordic_rsp_t rsp
);
  import tilt_pkg::*;

  localparam int IW      = (ARCTAN_ITERATIONS > 2) ? $clog2(ARCTAN_ITERATIONS) : 1;
  localparam int SHIFT   = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int R90     = 90 << ANGLE_FRAC_BITS;
  localparam logic [IW-1:0] LAST_ITER = IW'(ARCTAN_ITERATIONS - 1);
  localparam zacc_t Z_HALF  = Z_W'(1 << (SHIFT - 1));
  localparam zacc_t Z_90    = Z_W'(90 << ACC_FRAC);
  localparam zacc_t Z_SMAX  = Z_W'(32767);
  localparam zacc_t Z_SMIN  = -Z_W'(32768);
  localparam angle_t RES_P90 = (R90 > 32767) ? ANGLE_MAX : ANGLE_W'(R90);
  localparam angle_t RES_N90 = (R90 > 32768) ? ANGLE_MIN : ANGLE_W'(-R90);

  cordic_state_t   state, state_next;
  xy_t             x, y;
  zacc_t           z;
  logic [IW-1:0]   iter;
  logic            neg;
  angle_t          result;
  xy_t             dx, dy;
  zacc_t           t;
  xy_t             x_next, y_next;
  zacc_t           z_next;
  zacc_t           zc, rnd, signed_rnd;
  angle_t          rounded;
  logic [SAMPLE_W-1:0] mag_num, mag_den;
  logic            trivial;

  assign mag_num = SAMPLE_W'(req.num[AXIS_W-1] ? -req.num : req.num);
  assign mag_den = SAMPLE_W'(req.den[AXIS_W-1] ? -req.den : req.den);
  assign trivial = (req.num == '0) || (req.den == '0);

  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    t  = atan_step(TAB_IDX_W'(iter));
    if (!y[XY_W-1]) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + t;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - t;
    end
  end

  always_comb begin
    if (z[Z_W-1]) begin
      zc = '0;
    end else if (z > Z_90) begin
      zc = Z_90;
    end else begin
      zc = z;
    end
    rnd = (zc + Z_HALF) >>> SHIFT;
    signed_rnd = neg ? -rnd : rnd;
    if (signed_rnd > Z_SMAX) begin
      rounded = ANGLE_MAX;
    end else if (signed_rnd < Z_SMIN) begin
      rounded = ANGLE_MIN;
    end else begin
      rounded = ANGLE_W'(signed_rnd);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req.start) begin
          state_next = trivial ? CS_DONE : CS_RUN;
        end
      end
      CS_RUN: begin
        if (iter == LAST_ITER) begin
          state_next = CS_ROUND;
        end
      end
      CS_ROUND: state_next = CS_DONE;
      CS_DONE:  state_next = CS_IDLE;
      default:  state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == CS_DONE);
    rsp.result = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_IDLE: begin
        if (req.start) begin
          iter <= '0;
          neg  <= req.num[AXIS_W-1] ^ req.den[AXIS_W-1];
          x    <= {{(XY_W-SAMPLE_W-ACC_FRAC){1'b0}}, mag_den, {ACC_FRAC{1'b0}}};
          y    <= {{(XY_W-SAMPLE_W-ACC_FRAC){1'b0}}, mag_num, {ACC_FRAC{1'b0}}};
          z    <= '0;
          if (req.num == '0) begin
            result <= '0;
          end else if (req.den == '0) begin
            result <= req.num[AXIS_W-1] ? RES_N90 : RES_P90;
          end
        end
      end
      CS_RUN: begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        iter <= iter + 1'b1;
      end
      CS_ROUND: result <= rounded;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    state == CS_RUN |-> !x[XY_W-1])
    else $error("cordic x went negative");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    state == CS_DONE |=> state == CS_IDLE)
    else $error("cordic done held for more than one cycle");
  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == CS_RUN && iter == LAST_ITER) |=> state == CS_ROUND)
    else $error("cordic ran past its last iteration");
`endif

endmodule
